>>> rtl/set_difference_intersection_macros.svh
// assertion macros for the set difference / intersection rtl
// needs clk and arst_n in the scope of every use

`ifndef SET_DIFFERENCE_INTERSECTION_MACROS_SVH
`define SET_DIFFERENCE_INTERSECTION_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SDI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SDI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sdi_pkg.sv
// shared types and constants for the set difference / intersection block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdi_pkg;

	// command codes on the input word
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_PROBE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	// spare code, taken and dropped
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// mode register values
	localparam logic MODE_DIFF  = 1'b0;
	localparam logic MODE_ISECT = 1'b1;

	// entries in the queue between front and back
	localparam int unsigned QDEPTH = 4;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_PROBE,
		OP_CLEAR
	} op_t;

	// back end sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REF,
		ST_EMT,
		ST_OUT
	} state_t;

	// queue occupancy seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

>>> rtl/sdi_front.sv
// front end: takes input words, decodes the command and drops unused codes
// depends on sdi_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdi_front #(
	parameter int unsigned KEY_BITS = 16
) (
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [KEY_BITS-1:0]  key,
	input  wire sdi_pkg::q_stat_t     q_stat,
	output logic                      push,
	output sdi_pkg::op_t              push_op,
	output logic [KEY_BITS-1:0]       push_key
);

	logic known;

	always_comb begin
		known   = 1'b1;
		push_op = sdi_pkg::OP_LOAD;
		unique case (cmd)
			sdi_pkg::CMD_LOAD:  push_op = sdi_pkg::OP_LOAD;
			sdi_pkg::CMD_PROBE: push_op = sdi_pkg::OP_PROBE;
			sdi_pkg::CMD_CLEAR: push_op = sdi_pkg::OP_CLEAR;
			default:            known   = 1'b0;
		endcase
	end

	// unused code is taken and dropped, never queued
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full && known;
	assign push_key = key;

endmodule

`default_nettype wire

>>> rtl/sdi_queue.sv
// small fifo of decoded words between front and back
// depends on sdi_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdi_queue #(
	parameter int unsigned W = 18
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output sdi_pkg::q_stat_t  q_stat
);

	localparam int unsigned PW = $clog2(sdi_pkg::QDEPTH);
	localparam int unsigned NW = $clog2(sdi_pkg::QDEPTH + 1);

	logic [W-1:0]  slot_q [sdi_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign q_stat.full  = (cnt_q == NW'(sdi_pkg::QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_data     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/sdi_back.sv
// back end: reference and emitted key tables, scan sequencer, output register
// depends on sdi_pkg and set_difference_intersection_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "set_difference_intersection_macros.svh"

module sdi_back #(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                mode,
	input  wire sdi_pkg::q_stat_t    q_stat,
	input  wire sdi_pkg::op_t        op,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [KEY_BITS-1:0]      match_key
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [KEY_BITS-1:0] ref_mem [DEPTH];
	logic [KEY_BITS-1:0] emt_mem [DEPTH];
	logic [KEY_BITS-1:0] ref_rd_s1;
	logic [KEY_BITS-1:0] emt_rd_s1;

	sdi_pkg::state_t state_q;
	sdi_pkg::state_t state_d;

	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] match_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       ref_cnt_q;
	logic [CW-1:0]       emt_cnt_q;
	logic                pend_q;
	logic                out_valid_q;

	logic ref_eq;
	logic emt_eq;
	logic ref_end;
	logic emt_end;
	logic can_emit;
	logic ref_we;
	logic emt_we;
	logic out_load;
	logic scan_rst;
	logic issue;
	logic do_clear;

	// a compare is only meaningful in the cycle after its read was issued
	assign ref_eq   = pend_q && (ref_rd_s1 == key_q);
	assign emt_eq   = pend_q && (emt_rd_s1 == key_q);
	assign ref_end  = !pend_q && (idx_q == ref_cnt_q);
	assign emt_end  = !pend_q && (idx_q == emt_cnt_q);
	assign can_emit = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		ref_we   = 1'b0;
		emt_we   = 1'b0;
		out_load = 1'b0;
		scan_rst = 1'b0;
		do_clear = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			sdi_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					unique case (op)
						sdi_pkg::OP_LOAD:  ref_we = (ref_cnt_q != CW'(DEPTH));
						sdi_pkg::OP_CLEAR: do_clear = 1'b1;
						sdi_pkg::OP_PROBE: begin
							scan_rst = 1'b1;
							state_d  = sdi_pkg::ST_REF;
						end
						default: ;
					endcase
				end
			end
			sdi_pkg::ST_REF: begin
				issue = (idx_q < ref_cnt_q);
				if (ref_eq) begin
					if (mode == sdi_pkg::MODE_ISECT) begin
						scan_rst = 1'b1;
						state_d  = sdi_pkg::ST_EMT;
					end else begin
						state_d = sdi_pkg::ST_IDLE;
					end
				end else if (ref_end) begin
					state_d = (mode == sdi_pkg::MODE_ISECT) ? sdi_pkg::ST_IDLE
						: sdi_pkg::ST_OUT;
				end
			end
			sdi_pkg::ST_EMT: begin
				issue = (idx_q < emt_cnt_q);
				if (emt_eq) begin
					state_d = sdi_pkg::ST_IDLE;
				end else if (emt_end) begin
					emt_we  = (emt_cnt_q != CW'(DEPTH));
					state_d = sdi_pkg::ST_OUT;
				end
			end
			sdi_pkg::ST_OUT: begin
				if (can_emit) begin
					out_load = 1'b1;
					state_d  = sdi_pkg::ST_IDLE;
				end
			end
			default: state_d = sdi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table storage, no reset
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_cnt_q[AW-1:0]] <= key;
		end
		if (emt_we) begin
			emt_mem[emt_cnt_q[AW-1:0]] <= key_q;
		end
		ref_rd_s1 <= ref_mem[idx_q[AW-1:0]];
		emt_rd_s1 <= emt_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop && (op == sdi_pkg::OP_PROBE)) begin
			key_q <= key;
		end
		if (out_load) begin
			match_q <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pend_q      <= 1'b0;
			ref_cnt_q   <= '0;
			emt_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (scan_rst) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				pend_q <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (do_clear) begin
				ref_cnt_q <= '0;
				emt_cnt_q <= '0;
			end else begin
				if (ref_we) begin
					ref_cnt_q <= ref_cnt_q + CW'(1);
				end
				if (emt_we) begin
					emt_cnt_q <= emt_cnt_q + CW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign match_key = match_q;

	`SDI_ASSERT_NOW(a_ref_cnt_bound, 1'b1, ref_cnt_q <= CW'(DEPTH), "reference count past depth")
	`SDI_ASSERT_NOW(a_emt_le_ref, 1'b1, emt_cnt_q <= ref_cnt_q, "more emitted keys than references")
	`SDI_ASSERT_NOW(a_scan_idx, state_q == sdi_pkg::ST_REF, idx_q <= ref_cnt_q, "scan index past fill")
	`SDI_ASSERT_NEXT(a_clear_empties, do_clear, ref_cnt_q == '0 && emt_cnt_q == '0, "clear left entries")

endmodule

`default_nettype wire

>>> rtl/set_difference_intersection.sv
// Set difference / intersection engine. Load words (cmd 0) append a key to the
// reference table of up to DEPTH entries, further loads being dropped; probe
// words (cmd 1) look a key up; clear words (cmd 2) empty the reference and
// emitted tables; cmd 3 is taken and discarded. With mode 0 a probe key missing
// from the reference table comes out on match_key, duplicates included; with
// mode 1 a probe key found there comes out only the first time. In the back end,
// load and clear words are acted on as they are popped; a probe is popped, then
// walks the reference table one entry per cycle through the table memory's
// single read port, and in mode 1 a hit walks the emitted table the same way
// before the result goes to the output register. A four-word queue sits between
// the input decode and the scanner, and the result sits in its own output
// register, so the back end carries on while a result is stalled and input words
// are taken until a second result is held back and the queue fills. mode is to
// be written only while the block is idle; cfg_ready is always high.
// depends on sdi_pkg, sdi_front, sdi_queue, sdi_back
`timescale 1ns / 1ps
`default_nettype none

module set_difference_intersection #(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// mode register write
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_mode,
	// input words
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic [KEY_BITS-1:0] key,
	// result words
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [KEY_BITS-1:0]      match_key
);

	// queued word: operation code above the key
	localparam int unsigned QW = $bits(sdi_pkg::op_t) + KEY_BITS;

	logic                mode_q;
	sdi_pkg::q_stat_t    q_stat;
	logic                push;
	sdi_pkg::op_t        push_op;
	logic [KEY_BITS-1:0] push_key;
	logic                pop;
	logic [QW-1:0]       pop_data;
	sdi_pkg::op_t        head_op;
	logic [KEY_BITS-1:0] head_key;

	// mode register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sdi_pkg::MODE_DIFF;
		end else if (cfg_valid) begin
			mode_q <= cfg_mode;
		end
	end

	// front: decode and drop unused codes
	sdi_front #(
		.KEY_BITS (KEY_BITS)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.key      (key),
		.q_stat   (q_stat),
		.push     (push),
		.push_op  (push_op),
		.push_key (push_key)
	);

	// decoupling queue
	sdi_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_op, push_key}),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	assign head_op  = sdi_pkg::op_t'(pop_data[QW-1:KEY_BITS]);
	assign head_key = pop_data[KEY_BITS-1:0];

	// back: tables, scanner and output register
	sdi_back #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.q_stat    (q_stat),
		.op        (head_op),
		.key       (head_key),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.match_key (match_key)
	);

endmodule

`default_nettype wire

>>> verif/tb_set_difference_intersection.sv
// self-checking testbench for set_difference_intersection: directed and random
// load / probe / clear words, results checked against an in-bench membership model
// depends on sdi_pkg and the set_difference_intersection rtl
`timescale 1ns / 1ps

module tb_set_difference_intersection;

	localparam int unsigned DEPTH     = 16;
	localparam int unsigned KEY_BITS  = 16;
	// a queued word can take a full two-table walk, so allow five of those
	localparam int unsigned SETTLE    = 200;
	localparam int unsigned CYCLE_CAP = 1000000;
	localparam int unsigned SHOWN_MAX = 10;

	typedef logic [KEY_BITS-1:0] key_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic            cfg_mode;
	logic            in_valid;
	logic            in_stall;
	logic [1:0]      cmd;
	key_t            key;
	logic            out_valid;
	logic            out_stall;
	key_t            match_key;

	// membership model: reference table, emitted table and the mode register
	key_t            ref_keys[DEPTH];
	int unsigned     ref_count;
	key_t            emitted_keys[DEPTH];
	int unsigned     emitted_count;
	logic            mode_shadow;

	// keys still owed on match_key, oldest first
	key_t            pending_matches[$];

	int unsigned     mismatches;
	int unsigned     cycles;
	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	int unsigned     hold_request;
	int unsigned     hold_left;

	set_difference_intersection #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_mode  (cfg_mode),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.match_key (match_key)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// overall watchdog, counted in rising edges
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------
	// membership model
	// ---------------------------------------------------------------------------

	function automatic bit table_has(input key_t tab[DEPTH], input int unsigned cnt,
		input key_t k);
		for (int unsigned i = 0; i < cnt && i < DEPTH; i++) begin
			if (tab[i] == k)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// update the model with one accepted word and queue any key it produces
	function automatic void predict_membership(input logic [1:0] c, input key_t k);
		bit present;
		if (c == sdi_pkg::CMD_LOAD) begin
			// a full table drops the key
			if (ref_count < DEPTH) begin
				ref_keys[ref_count] = k;
				ref_count++;
			end
		end else if (c == sdi_pkg::CMD_CLEAR) begin
			ref_count     = 0;
			emitted_count = 0;
		end else if (c == sdi_pkg::CMD_PROBE) begin
			present = table_has(ref_keys, ref_count, k);
			if (mode_shadow == sdi_pkg::MODE_DIFF) begin
				if (!present)
					pending_matches.push_back(k);
			end else if (present && !table_has(emitted_keys, emitted_count, k)) begin
				if (emitted_count < DEPTH) begin
					emitted_keys[emitted_count] = k;
					emitted_count++;
				end
				pending_matches.push_back(k);
			end
		end
		// the spare command code is swallowed with no effect
	endfunction

	// ---------------------------------------------------------------------------
	// result side: stall driver and checker
	// ---------------------------------------------------------------------------

	// stall changes on the falling edge; a requested hold-off overrides the dice
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// every word taken on the result channel must be the oldest owed key
	always @(posedge clk) begin
		key_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("unexpected result word: match_key %h at cycle %0d",
						match_key, cycles);
			end else begin
				want = pending_matches.pop_front();
				if (match_key !== want) begin
					mismatches++;
					if (mismatches <= SHOWN_MAX)
						$display("match_key mismatch: expected %h, got %h at cycle %0d",
							want, match_key, cycles);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------------------

	// offer one word, with random idle cycles in front of it, and wait until taken;
	// valid is left high so a following word can go straight out
	task automatic send_word(input logic [1:0] c, input key_t k);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd      = c;
		key      = k;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict_membership(c, k);
	endtask

	// drop valid and wait for every owed result, optionally letting the pipe settle
	task automatic drain_results(input bit settle);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE) @(posedge clk);
	endtask

	// mode is only written once the block has gone quiet
	task automatic write_mode(input logic m);
		drain_results(1'b1);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_mode  = m;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		mode_shadow = m;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic key_t any_key();
		return key_t'($urandom);
	endfunction

	// ---------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------

	// difference mode straight out of reset: empty table, extremes, duplicates,
	// the spare command and a clear
	task automatic test_difference_directed();
		send_word(sdi_pkg::CMD_PROBE, 16'hFFFF);   // empty table, every key absent
		send_word(sdi_pkg::CMD_LOAD,  16'h0000);
		send_word(sdi_pkg::CMD_LOAD,  16'hFFFF);
		send_word(sdi_pkg::CMD_LOAD,  16'hFFFF);   // duplicate load
		send_word(sdi_pkg::CMD_PROBE, 16'h0000);
		send_word(sdi_pkg::CMD_PROBE, 16'hFFFF);
		send_word(sdi_pkg::CMD_PROBE, 16'h8001);
		send_word(sdi_pkg::CMD_SPARE, 16'hAAAA);   // spare code, ignored
		send_word(sdi_pkg::CMD_PROBE, 16'hAAAA);
		send_word(sdi_pkg::CMD_CLEAR, 16'h5555);
		send_word(sdi_pkg::CMD_PROBE, 16'h0000);   // cleared, so absent again
		send_word(sdi_pkg::CMD_PROBE, 16'h0000);   // duplicates pass in this mode
	endtask

	// intersection mode: a common key goes out once, until a clear forgets it
	task automatic test_intersection_directed();
		write_mode(sdi_pkg::MODE_ISECT);
		send_word(sdi_pkg::CMD_LOAD,  16'h1234);
		send_word(sdi_pkg::CMD_LOAD,  16'h1234);
		send_word(sdi_pkg::CMD_PROBE, 16'h1234);
		send_word(sdi_pkg::CMD_PROBE, 16'h1234);
		send_word(sdi_pkg::CMD_PROBE, 16'h4321);
		send_word(sdi_pkg::CMD_CLEAR, 16'h0000);
		send_word(sdi_pkg::CMD_PROBE, 16'h1234);
		send_word(sdi_pkg::CMD_LOAD,  16'h1234);
		send_word(sdi_pkg::CMD_PROBE, 16'h1234);
	endtask

	// long hold-off on the result side while probes keep coming, so that the
	// internal queue fills and the input is stalled
	task automatic test_backpressure();
		write_mode(sdi_pkg::MODE_DIFF);
		send_word(sdi_pkg::CMD_CLEAR, 16'h0000);
		drain_results(1'b0);
		@(posedge clk);
		hold_request = 400;
		for (int i = 0; i < 30; i++)
			send_word(sdi_pkg::CMD_PROBE, any_key());
		drain_results(1'b0);
	endtask

	// one clear / load / probe run over a small key pool so hits are common;
	// some runs overfill the reference table
	task automatic send_set_run(inout int unsigned sent);
		key_t        pool[8];
		int unsigned n_loads;
		int unsigned n_probes;
		foreach (pool[i]) begin
			case ($urandom_range(9))
				0:       pool[i] = '0;
				1:       pool[i] = '1;
				default: pool[i] = any_key();
			endcase
		end
		n_loads  = ($urandom_range(4) == 0) ? $urandom_range(DEPTH + 4, DEPTH)
			: $urandom_range(DEPTH, 0);
		n_probes = $urandom_range(30, 8);
		send_word(sdi_pkg::CMD_CLEAR, any_key());
		sent++;
		for (int unsigned i = 0; i < n_loads; i++) begin
			send_word(sdi_pkg::CMD_LOAD,
				($urandom_range(2) != 0) ? pool[$urandom_range(7)] : any_key());
			sent++;
		end
		for (int unsigned i = 0; i < n_probes; i++) begin
			if ($urandom_range(19) == 0)
				send_word(sdi_pkg::CMD_SPARE, any_key());
			else if ($urandom_range(9) == 0)
				send_word(sdi_pkg::CMD_LOAD, pool[$urandom_range(7)]);
			else
				send_word(sdi_pkg::CMD_PROBE,
					($urandom_range(9) < 7) ? pool[$urandom_range(7)] : any_key());
			sent++;
		end
	endtask

	// random phase: mostly well-formed runs, some raw noise, the odd full pause
	task automatic test_random(input int unsigned words, input logic m,
		input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned sent;
		sent = 0;
		write_mode(m);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < words) begin
			if ($urandom_range(6) != 0) begin
				send_set_run(sent);
			end else begin
				repeat (10) begin
					send_word(2'($urandom_range(3)), any_key());
					sent++;
				end
			end
			// sender waits for every owed result now and then
			if ($urandom_range(5) == 0)
				drain_results(1'b0);
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_mode       = 1'b0;
		in_valid       = 1'b0;
		cmd            = sdi_pkg::CMD_LOAD;
		key            = '0;
		out_stall      = 1'b0;
		mismatches     = 0;
		cycles         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 0;
		hold_left      = 0;
		ref_count      = 0;
		emitted_count  = 0;
		mode_shadow    = sdi_pkg::MODE_DIFF;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_difference_directed();
		test_intersection_directed();
		test_backpressure();
		test_random(175, sdi_pkg::MODE_DIFF,  0,  0);
		test_random(175, sdi_pkg::MODE_ISECT, 0,  0);
		test_random(175, sdi_pkg::MODE_DIFF,  57, 0);
		test_random(175, sdi_pkg::MODE_ISECT, 57, 0);
		test_random(175, sdi_pkg::MODE_ISECT, 0,  57);
		test_random(175, sdi_pkg::MODE_DIFF,  0,  57);
		test_random(175, sdi_pkg::MODE_DIFF,  17, 17);
		test_random(175, sdi_pkg::MODE_ISECT, 17, 17);

		drain_results(1'b1);
		if (mismatches == 0 && pending_matches.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
